FILE: hdl/wavp_pkg.sv
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared constants, state codes and controller/datapath bundles for the
// RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

    localparam int unsigned LOOKUP_LIMIT = 524288;
    localparam int unsigned POS_W        = $clog2(LOOKUP_LIMIT + 8);

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] FMT_FLOAT = 16'h0003;
    localparam logic [31:0] FMT_LOOK  = 32'd16;
    localparam logic [9:0]  DUR_SCALE = 10'd1000;

    localparam int unsigned DIV_N_W = 42;
    localparam int unsigned DIV_C_W = $clog2(DIV_N_W + 1);

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_CODEC   = 2'd2;

    localparam logic [5:0] FLAGS_FMT     = 6'h07;
    localparam logic [5:0] FLAG_DURATION = 6'h10;
    localparam logic [5:0] FLAGS_DATA    = 6'h28;

    localparam logic [3:0] IDX_RIFF_END = 4'd3;
    localparam logic [3:0] IDX_WAVE_END = 4'd11;
    localparam logic [3:0] IDX_TAG_END  = 4'd3;
    localparam logic [3:0] IDX_HDR_END  = 4'd7;
    localparam logic [3:0] IDX_FMT_END  = 4'd15;

    localparam int unsigned STATE_W = 4;
    localparam logic [STATE_W-1:0] ST_RIFF  = 4'd0;
    localparam logic [STATE_W-1:0] ST_CHUNK = 4'd1;
    localparam logic [STATE_W-1:0] ST_FMT   = 4'd2;
    localparam logic [STATE_W-1:0] ST_SKIP  = 4'd3;
    localparam logic [STATE_W-1:0] ST_DONE  = 4'd4;
    localparam logic [STATE_W-1:0] ST_HDR   = 4'd5;
    localparam logic [STATE_W-1:0] ST_MUL1  = 4'd6;
    localparam logic [STATE_W-1:0] ST_MUL2  = 4'd7;
    localparam logic [STATE_W-1:0] ST_FCHK  = 4'd8;
    localparam logic [STATE_W-1:0] ST_DIV   = 4'd9;

    typedef struct packed {
        logic       restart;
        logic       shift_tag;
        logic       shift_len;
        logic       shift_fmt;
        logic       pos_inc;
        logic       skip_dec;
        logic       mul1;
        logic       mul2;
        logic       fmt_commit;
        logic       start_skip;
        logic       skip_fmt;
        logic       div_start;
        logic       load_ok;
        logic       dur_div;
        logic       load_fail;
        logic [1:0] fail_code;
    } wavp_cmd_t;

    typedef struct packed {
        logic riff_ok;
        logic wave_ok;
        logic tag_fmt;
        logic tag_data;
        logic fmt_ok;
        logic fmt_short;
        logic limit_hit;
        logic skip_zero;
        logic skip_last;
        logic div_need;
        logic div_done;
    } wavp_sts_t;

endpackage

FILE: hdl/wavp_div.sv
// ----------------------------------------------------------------------------
// wavp_div
// Restoring divider, one quotient bit per cycle, for the duration figure.
// ----------------------------------------------------------------------------
module wavp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wavp_pkg::DIV_N_W-1:0]  dividend,
    input  logic [31:0]                   divisor,
    output logic                          done,
    output logic [31:0]                   quotient
);
    import wavp_pkg::*;

    logic [32:0]          rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [31:0]          dvs_reg;
    logic [DIV_C_W-1:0]   cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [32:0]          rem_sh;
    logic                 q_bit;

    assign rem_sh = {rem_reg[31:0], quo_reg[DIV_N_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_C_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_C_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_reg <= {quo_reg[DIV_N_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[31:0];

endmodule

FILE: hdl/wavp_dpath.sv
// ----------------------------------------------------------------------------
// wavp_dpath
// Header field registers, fmt arithmetic, skip counter and result register.
// ----------------------------------------------------------------------------
module wavp_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  wavp_pkg::wavp_cmd_t cmd,
    output wavp_pkg::wavp_sts_t sts,
    input  logic [7:0]          file_byte,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    output logic [1:0]          status,
    output logic [19:0]         header_length,
    output logic [31:0]         data_length,
    output logic [15:0]         num_channels,
    output logic [31:0]         samples_per_sec,
    output logic [7:0]          sample_bits,
    output logic                float_samples,
    output logic [20:0]         frame_bytes,
    output logic [31:0]         bitrate,
    output logic [31:0]         duration_ms,
    output logic [5:0]          info_flags
);
    import wavp_pkg::*;

    logic [31:0]      file_len_reg;
    logic [31:0]      tag_reg;
    logic [31:0]      len_reg;
    logic [POS_W-1:0] pos_reg;
    logic [31:0]      skip_reg;
    logic [127:0]     fmt_reg;
    logic [15:0]      ch_reg;
    logic [31:0]      rate_reg;
    logic [7:0]       depth_reg;
    logic             float_reg;
    logic [31:0]      prod_reg;
    logic [31:0]      rbytes_reg;
    logic [20:0]      block_reg;
    logic [5:0]       flags_reg;

    logic [1:0]  res_status_reg;
    logic [19:0] res_hdr_reg;
    logic [31:0] res_len_reg;
    logic [15:0] res_ch_reg;
    logic [31:0] res_rate_reg;
    logic [7:0]  res_depth_reg;
    logic        res_float_reg;
    logic [20:0] res_block_reg;
    logic [31:0] res_bitrate_reg;
    logic [31:0] res_dur_reg;
    logic [5:0]  res_flags_reg;

    logic [31:0]        tag_next;
    logic [31:0]        len_next;
    logic [15:0]        fmt_tag;
    logic [16:0]        depth_sum;
    logic [7:0]         depth_rnd;
    logic [47:0]        prod_full;
    logic [39:0]        rb_full;
    logic [23:0]        blk_full;
    logic [31:0]        skip_len;
    logic [32:0]        target;
    logic [31:0]        size;
    logic [DIV_N_W-1:0] size_x1000;
    logic               div_done;
    logic [31:0]        div_quo;

    assign tag_next  = {file_byte, tag_reg[31:8]};
    assign len_next  = {file_byte, len_reg[31:8]};
    assign fmt_tag   = fmt_reg[15:0];
    assign depth_sum = {1'b0, fmt_reg[127:112]} + 17'd7;
    assign depth_rnd = {depth_sum[7:3], 3'b000};
    assign prod_full = {32'd0, fmt_reg[31:16]} * {16'd0, fmt_reg[63:32]};
    assign rb_full   = {8'd0, prod_reg} * {32'd0, depth_reg};
    assign blk_full  = {8'd0, ch_reg} * {16'd0, depth_reg};
    assign skip_len  = cmd.skip_fmt ? (len_reg - FMT_LOOK) : len_reg;
    assign target    = {1'b0, skip_len} + 33'(pos_reg);
    assign size      = (len_reg != 32'd0) ? len_reg : file_len_reg;
    assign size_x1000 = {10'd0, size} * {32'd0, DUR_SCALE};

    assign sts.riff_ok   = (tag_next == TAG_RIFF);
    assign sts.wave_ok   = (tag_next == TAG_WAVE);
    assign sts.tag_fmt   = (tag_reg == TAG_FMT);
    assign sts.tag_data  = (tag_reg == TAG_DATA);
    assign sts.fmt_ok    = (fmt_tag == FMT_PCM) || (fmt_tag == FMT_FLOAT);
    assign sts.fmt_short = (len_reg < FMT_LOOK);
    assign sts.limit_hit = (target >= 33'(LOOKUP_LIMIT));
    assign sts.skip_zero = (skip_len == 32'd0);
    assign sts.skip_last = (skip_reg == 32'd1);
    assign sts.div_need  = (size != 32'd0) && (rbytes_reg != 32'd0);
    assign sts.div_done  = div_done;

    wavp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (size_x1000),
        .divisor  (rbytes_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_len_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            file_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg    <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            skip_reg   <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            depth_reg  <= '0;
            float_reg  <= 1'b0;
            rbytes_reg <= '0;
            flags_reg  <= '0;
        end
        else if (cmd.restart)
        begin
            tag_reg    <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            skip_reg   <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            depth_reg  <= '0;
            float_reg  <= 1'b0;
            rbytes_reg <= '0;
            flags_reg  <= '0;
        end
        else
        begin
            if (cmd.shift_tag)
            begin
                tag_reg <= tag_next;
            end
            if (cmd.shift_len)
            begin
                len_reg <= len_next;
            end
            if (cmd.pos_inc)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.start_skip && !sts.limit_hit)
            begin
                pos_reg  <= target[POS_W-1:0];
                skip_reg <= skip_len;
            end
            if (cmd.skip_dec)
            begin
                skip_reg <= skip_reg - 1'b1;
            end
            if (cmd.mul1)
            begin
                ch_reg    <= fmt_reg[31:16];
                rate_reg  <= fmt_reg[63:32];
                depth_reg <= depth_rnd;
                float_reg <= (fmt_tag == FMT_FLOAT);
            end
            if (cmd.mul2)
            begin
                rbytes_reg <= {3'b000, rb_full[31:3]};
            end
            if (cmd.fmt_commit)
            begin
                flags_reg <= flags_reg | FLAGS_FMT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_fmt)
        begin
            fmt_reg <= {file_byte, fmt_reg[127:8]};
        end
        if (cmd.mul1)
        begin
            prod_reg <= prod_full[31:0];
        end
        if (cmd.fmt_commit)
        begin
            block_reg <= blk_full[23:3];
        end
        if (cmd.load_ok)
        begin
            res_status_reg  <= STS_OK;
            res_hdr_reg     <= 20'(pos_reg);
            res_len_reg     <= size;
            res_ch_reg      <= ch_reg;
            res_rate_reg    <= rate_reg;
            res_depth_reg   <= depth_reg;
            res_float_reg   <= float_reg;
            res_block_reg   <= (flags_reg[0]) ? block_reg : 21'd0;
            res_bitrate_reg <= {rbytes_reg[28:0], 3'b000};
            res_dur_reg     <= cmd.dur_div ? div_quo : 32'd0;
            res_flags_reg   <= flags_reg | FLAGS_DATA | (cmd.dur_div ? FLAG_DURATION : 6'd0);
        end
        else if (cmd.load_fail)
        begin
            res_status_reg  <= cmd.fail_code;
            res_hdr_reg     <= '0;
            res_len_reg     <= '0;
            res_ch_reg      <= '0;
            res_rate_reg    <= '0;
            res_depth_reg   <= '0;
            res_float_reg   <= 1'b0;
            res_block_reg   <= '0;
            res_bitrate_reg <= '0;
            res_dur_reg     <= '0;
            res_flags_reg   <= '0;
        end
    end

    assign status          = res_status_reg;
    assign header_length   = res_hdr_reg;
    assign data_length     = res_len_reg;
    assign num_channels    = res_ch_reg;
    assign samples_per_sec = res_rate_reg;
    assign sample_bits     = res_depth_reg;
    assign float_samples   = res_float_reg;
    assign frame_bytes     = res_block_reg;
    assign bitrate         = res_bitrate_reg;
    assign duration_ms     = res_dur_reg;
    assign info_flags      = res_flags_reg;

endmodule

FILE: hdl/wavp_ctrl.sv
// ----------------------------------------------------------------------------
// wavp_ctrl
// Parse phase state machine, byte counter, handshakes and end-of-file
// handling.
// ----------------------------------------------------------------------------
module wavp_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wavp_pkg::wavp_cmd_t           cmd,
    input  wavp_pkg::wavp_sts_t           sts,
    output logic [wavp_pkg::STATE_W-1:0]  state
);
    import wavp_pkg::*;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [3:0]         idx_reg;
    logic [3:0]         idx_next;
    logic               last_pend_reg;
    logic               last_pend_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               rest;
    logic               in_fire;
    logic               step_end;
    logic               loaded;
    logic               last_now;

    assign rest = (state_reg == ST_RIFF) || (state_reg == ST_CHUNK) ||
                  (state_reg == ST_FMT) || (state_reg == ST_SKIP) ||
                  (state_reg == ST_DONE);
    assign in_ready = rest && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        idx_next   = idx_reg;
        step_end   = 1'b0;
        loaded     = 1'b0;
        last_now   = last_pend_reg;
        unique case (state_reg)
            ST_RIFF:
            begin
                if (in_fire)
                begin
                    cmd.shift_tag = 1'b1;
                    cmd.pos_inc   = 1'b1;
                    last_now      = last_byte;
                    step_end      = 1'b1;
                    if ((idx_reg == IDX_RIFF_END && !sts.riff_ok) ||
                        (idx_reg == IDX_WAVE_END && !sts.wave_ok))
                    begin
                        cmd.load_fail = 1'b1;
                        cmd.fail_code = STS_INVALID;
                        loaded        = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else if (idx_reg == IDX_WAVE_END)
                    begin
                        state_next = ST_CHUNK;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_CHUNK:
            begin
                if (in_fire)
                begin
                    cmd.pos_inc   = 1'b1;
                    cmd.shift_tag = (idx_reg <= IDX_TAG_END);
                    cmd.shift_len = (idx_reg > IDX_TAG_END);
                    if (idx_reg == IDX_HDR_END)
                    begin
                        idx_next   = '0;
                        state_next = ST_HDR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        last_now = last_byte;
                        step_end = 1'b1;
                    end
                end
            end
            ST_HDR:
            begin
                step_end = 1'b1;
                if (sts.tag_fmt)
                begin
                    state_next = ST_FMT;
                end
                else if (sts.tag_data)
                begin
                    if (sts.div_need)
                    begin
                        cmd.div_start = 1'b1;
                        step_end      = 1'b0;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.load_ok = 1'b1;
                        loaded      = 1'b1;
                        state_next  = ST_DONE;
                    end
                end
                else
                begin
                    cmd.start_skip = 1'b1;
                    if (sts.limit_hit)
                    begin
                        cmd.load_fail = 1'b1;
                        cmd.fail_code = STS_INVALID;
                        loaded        = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = sts.skip_zero ? ST_CHUNK : ST_SKIP;
                    end
                end
            end
            ST_FMT:
            begin
                if (in_fire)
                begin
                    cmd.shift_fmt = 1'b1;
                    cmd.pos_inc   = 1'b1;
                    if (idx_reg == IDX_FMT_END)
                    begin
                        idx_next   = '0;
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        last_now = last_byte;
                        step_end = 1'b1;
                    end
                end
            end
            ST_MUL1:
            begin
                if (!sts.fmt_ok)
                begin
                    cmd.load_fail = 1'b1;
                    cmd.fail_code = STS_CODEC;
                    loaded        = 1'b1;
                    step_end      = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.mul1   = 1'b1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                cmd.fmt_commit = 1'b1;
                step_end       = 1'b1;
                if (sts.fmt_short)
                begin
                    cmd.load_fail = 1'b1;
                    cmd.fail_code = STS_INVALID;
                    loaded        = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.start_skip = 1'b1;
                    cmd.skip_fmt   = 1'b1;
                    if (sts.limit_hit)
                    begin
                        cmd.load_fail = 1'b1;
                        cmd.fail_code = STS_INVALID;
                        loaded        = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = sts.skip_zero ? ST_CHUNK : ST_SKIP;
                    end
                end
            end
            ST_SKIP:
            begin
                if (in_fire)
                begin
                    cmd.skip_dec = 1'b1;
                    last_now     = last_byte;
                    step_end     = 1'b1;
                    if (sts.skip_last)
                    begin
                        state_next = ST_CHUNK;
                        idx_next   = '0;
                    end
                end
            end
            ST_DONE:
            begin
                if (in_fire)
                begin
                    last_now = last_byte;
                    step_end = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.load_ok = 1'b1;
                    cmd.dur_div = 1'b1;
                    loaded      = 1'b1;
                    step_end    = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_RIFF;
                idx_next   = '0;
            end
        endcase

        // end of file: report early end, then start over
        if (step_end && last_now)
        begin
            if (!loaded && state_next != ST_DONE)
            begin
                cmd.load_fail = 1'b1;
                cmd.fail_code = STS_INVALID;
                loaded        = 1'b1;
            end
            cmd.restart = 1'b1;
            state_next  = ST_RIFF;
            idx_next    = '0;
        end
    end

    assign last_pend_next = step_end ? 1'b0 : (in_fire ? last_byte : last_pend_reg);
    assign out_valid_next = loaded ? 1'b1 : ((out_valid_reg && out_ready) ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RIFF;
            idx_reg       <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule

FILE: hdl/wav_header_chunk_parser.sv
// ----------------------------------------------------------------------------
// wav_header_chunk_parser
// Byte-serial RIFF/WAVE header parser reporting stream format on the data chunk.
//
//   channel   signals                           direction
//   input     in_valid/in_ready, file_byte,     in
//             last_byte
//   result    out_valid/out_ready, status ...   out
//             info_flags
//   config    cfg_wr_en, cfg_wr_data            in (file_length)
//
// one byte per cycle in tag, header, fmt and skip phases while input is not stalled
// each completed chunk header adds a decode state (ST_HDR); a fmt chunk adds the
// multiplier and check states ST_MUL1, ST_MUL2 and ST_FCHK
// the data result waits for the bit-serial divider (ST_DIV) when a duration is
// computed
// no clearing pass after reset; input stalls while decoding or dividing and
// while a result transaction waits for out_ready
// ----------------------------------------------------------------------------
module wav_header_chunk_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [19:0] header_length,
    output logic [31:0] data_length,
    output logic [15:0] num_channels,
    output logic [31:0] samples_per_sec,
    output logic [7:0]  sample_bits,
    output logic        float_samples,
    output logic [20:0] frame_bytes,
    output logic [31:0] bitrate,
    output logic [31:0] duration_ms,
    output logic [5:0]  info_flags,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import wavp_pkg::*;

    wavp_cmd_t          cmd;
    wavp_sts_t          sts;
    logic [STATE_W-1:0] state;

    wavp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .state     (state)
    );

    wavp_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .file_byte       (file_byte),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .status          (status),
        .header_length   (header_length),
        .data_length     (data_length),
        .num_channels    (num_channels),
        .samples_per_sec (samples_per_sec),
        .sample_bits     (sample_bits),
        .float_samples   (float_samples),
        .frame_bytes     (frame_bytes),
        .bitrate         (bitrate),
        .duration_ms     (duration_ms),
        .info_flags      (info_flags)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STS_OK) |-> (info_flags == 6'd0 && data_length == 32'd0))
        else $error("error transaction carries payload");

    a_ok_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STS_OK) |-> (info_flags[3] && info_flags[5]))
        else $error("ok transaction missing size flags");

    a_no_dur: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STS_OK && !info_flags[4]) |-> (duration_ms == 32'd0))
        else $error("duration without flag");

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_DIV || state == ST_HDR || state == ST_MUL1) |-> !in_ready)
        else $error("input taken while decoding");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RIFF/WAVE header parser. Byte streams of whole
// files (well-formed and broken) are pushed through the input channel; a
// behavioral parser in the bench predicts each format report, which is
// compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_top;
    import wavp_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] header_length;
        logic [31:0] data_length;
        logic [15:0] num_channels;
        logic [31:0] samples_per_sec;
        logic [7:0]  sample_bits;
        logic        float_samples;
        logic [20:0] frame_bytes;
        logic [31:0] bitrate;
        logic [31:0] duration_ms;
        logic [5:0]  info_flags;
    } fmt_report_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  file_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    fmt_report_t got;

    fmt_report_t report_q[$];
    int          errors;
    int          idle_cycles;
    int          n_bytes;
    bit          hold_off;
    bit          no_stall;

    // predictor state
    logic [31:0] p_file_length;
    logic [3:0]  p_phase;
    logic [4:0]  p_idx;
    logic [31:0] p_tag;
    logic [31:0] p_len;
    logic [7:0]  p_fmt[16];
    logic [32:0] p_pos;
    logic [32:0] p_skip;
    logic [15:0] p_chan;
    logic [31:0] p_rate;
    logic [7:0]  p_depth;
    logic        p_float;
    logic [31:0] p_rate_bytes;
    logic [5:0]  p_flags;

    byte unsigned file_buf[$];

    wav_header_chunk_parser DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .file_byte(file_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(got.status), .header_length(got.header_length),
        .data_length(got.data_length), .num_channels(got.num_channels),
        .samples_per_sec(got.samples_per_sec), .sample_bits(got.sample_bits),
        .float_samples(got.float_samples), .frame_bytes(got.frame_bytes),
        .bitrate(got.bitrate), .duration_ms(got.duration_ms),
        .info_flags(got.info_flags),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void parser_restart();
        p_phase = ST_RIFF;
        p_idx = '0;
        p_tag = '0;
        p_len = '0;
        p_pos = '0;
        p_skip = '0;
        p_chan = '0;
        p_rate = '0;
        p_depth = '0;
        p_float = 1'b0;
        p_rate_bytes = '0;
        p_flags = '0;
    endfunction

    function automatic void push_fail(logic [1:0] code);
        fmt_report_t r;
        r = '0;
        r.status = code;
        report_q.push_back(r);
        p_phase = ST_DONE;
    endfunction

    function automatic bit begin_skip(logic [32:0] len);
        logic [32:0] target;
        target = p_pos + len;
        p_idx = '0;
        if (target >= 33'(LOOKUP_LIMIT))
            return 1'b1;
        p_pos = target;
        p_skip = len;
        p_phase = (len == 0) ? ST_CHUNK : ST_SKIP;
        return 1'b0;
    endfunction

    function automatic void push_data_report();
        fmt_report_t r;
        logic [31:0] size;
        logic [63:0] q;
        size = (p_len != 0) ? p_len : p_file_length;
        r = '0;
        r.status = STS_OK;
        r.header_length = p_pos[19:0];
        r.data_length = size;
        r.num_channels = p_chan;
        r.samples_per_sec = p_rate;
        r.sample_bits = p_depth;
        r.float_samples = p_float;
        r.frame_bytes = 21'((32'(p_chan) * 32'(p_depth)) / 8);
        r.bitrate = p_rate_bytes * 32'd8;
        r.info_flags = p_flags | FLAGS_DATA;
        if (size != 0 && p_rate_bytes != 0) begin
            q = (64'(size) * 64'd1000) / 64'(p_rate_bytes);
            r.duration_ms = q[31:0];
            r.info_flags = r.info_flags | FLAG_DURATION;
        end
        report_q.push_back(r);
        p_phase = ST_DONE;
    endfunction

    function automatic bit close_fmt();
        logic [15:0] tag;
        logic [31:0] depth;
        tag = {p_fmt[1], p_fmt[0]};
        if (tag != FMT_PCM && tag != FMT_FLOAT) begin
            push_fail(STS_CODEC);
            return 1'b1;
        end
        p_chan = {p_fmt[3], p_fmt[2]};
        p_rate = {p_fmt[7], p_fmt[6], p_fmt[5], p_fmt[4]};
        depth = {16'h0, p_fmt[15], p_fmt[14]};
        p_depth = 8'(32'd8 * ((depth + 32'd7) / 32'd8));
        p_float = (tag == FMT_FLOAT);
        p_rate_bytes = ((32'(p_chan) * p_rate) * 32'(p_depth)) / 32'd8;
        p_flags = p_flags | FLAGS_FMT;
        if (p_len < FMT_LOOK || begin_skip(33'(p_len - FMT_LOOK))) begin
            push_fail(STS_INVALID);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        bit made;
        made = 1'b0;
        case (p_phase)
            ST_RIFF: begin
                p_tag = {b, p_tag[31:8]};
                p_pos = p_pos + 1;
                if (p_idx == 3 && p_tag != TAG_RIFF) begin
                    push_fail(STS_INVALID);
                    made = 1'b1;
                end else if (p_idx >= 11) begin
                    if (p_tag != TAG_WAVE) begin
                        push_fail(STS_INVALID);
                        made = 1'b1;
                    end else begin
                        p_phase = ST_CHUNK;
                        p_idx = '0;
                    end
                end else
                    p_idx = p_idx + 1;
            end
            ST_CHUNK: begin
                p_pos = p_pos + 1;
                if (p_idx < 4)
                    p_tag = {b, p_tag[31:8]};
                else
                    p_len = {b, p_len[31:8]};
                if (p_idx >= 7) begin
                    p_idx = '0;
                    if (p_tag == TAG_FMT)
                        p_phase = ST_FMT;
                    else if (p_tag == TAG_DATA) begin
                        push_data_report();
                        made = 1'b1;
                    end else if (begin_skip(33'(p_len))) begin
                        push_fail(STS_INVALID);
                        made = 1'b1;
                    end
                end else
                    p_idx = p_idx + 1;
            end
            ST_FMT: begin
                p_fmt[p_idx[3:0]] = b;
                p_pos = p_pos + 1;
                if (p_idx >= 15)
                    made = close_fmt();
                else
                    p_idx = p_idx + 1;
            end
            ST_SKIP: begin
                if (p_skip > 0)
                    p_skip = p_skip - 1;
                if (p_skip == 0) begin
                    p_phase = ST_CHUNK;
                    p_idx = '0;
                end
            end
            default: ;
        endcase
        if (last) begin
            if (!made && p_phase != ST_DONE)
                push_fail(STS_INVALID);
            parser_restart();
        end
    endfunction

    // sender: bursts with random gaps
    task automatic send_byte(logic [7:0] b, logic last);
        if ($urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        file_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b, last);
        n_bytes++;
    endtask

    task automatic send_file();
        foreach (file_buf[i])
            send_byte(file_buf[i], i == file_buf.size() - 1);
        file_buf.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_file_length(logic [31:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        p_file_length = v;
    endtask

    task automatic put_tag(logic [31:0] t);
        for (int i = 0; i < 4; i++)
            file_buf.push_back(t[8*i +: 8]);
    endtask

    task automatic put_hdr(logic [31:0] t, logic [31:0] len);
        put_tag(t);
        put_tag(len);
    endtask

    task automatic put_fmt(logic [15:0] tag, logic [15:0] ch, logic [31:0] rate,
                           logic [15:0] bits, logic [31:0] len);
        put_hdr(TAG_FMT, len);
        put_tag({ch, tag});
        put_tag(rate);
        put_tag($urandom);
        put_tag({bits, 16'($urandom)});
        for (int i = 16; i < len && i < 40; i++)
            file_buf.push_back(8'($urandom));
    endtask

    // random well-formed file with optional breakage
    task automatic build_random_file();
        int kind;
        logic [15:0] ftag;
        kind = $urandom_range(0, 19);
        put_tag(kind == 0 ? $urandom : TAG_RIFF);
        put_tag($urandom);
        put_tag(kind == 1 ? $urandom : TAG_WAVE);
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0: begin
                    int n;
                    n = $urandom_range(0, 12);
                    put_hdr($urandom, n);
                    repeat (n) file_buf.push_back(8'($urandom));
                end
                1: begin
                    ftag = ($urandom_range(0, 1)) ? FMT_PCM : FMT_FLOAT;
                    if (kind == 2) ftag = 16'($urandom);
                    put_fmt(ftag, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                : 16'($urandom_range(1, 8)),
                            ($urandom_range(0, 3) == 0) ? $urandom : 44100,
                            ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 33)),
                            (kind == 3) ? $urandom_range(0, 15) : $urandom_range(16, 24));
                end
                default: put_fmt(FMT_PCM, 16'($urandom_range(1, 2)), $urandom, 16, 16);
            endcase
        end
        if (kind == 4)
            put_hdr($urandom, $urandom_range(LOOKUP_LIMIT - 40, LOOKUP_LIMIT + 40));
        put_hdr(TAG_DATA, ($urandom_range(0, 3) == 0) ? 0 : $urandom);
        repeat ($urandom_range(0, 4)) file_buf.push_back(8'($urandom));
        if (kind == 5)
            file_buf = file_buf[0:$urandom_range(0, file_buf.size() - 1)];
    endtask

    task automatic test_directed();
        write_file_length(32'hFFFF_FFFF);
        // minimal float file, zero data size falls back to register
        put_tag(TAG_RIFF); put_tag(0); put_tag(TAG_WAVE);
        put_fmt(FMT_FLOAT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16);
        put_hdr(TAG_DATA, 0);
        file_buf.push_back(8'hFF);
        send_file();
        // no fmt chunk, data is last byte
        put_tag(TAG_RIFF); put_tag(0); put_tag(TAG_WAVE); put_hdr(TAG_DATA, 100);
        send_file();
        // bad riff, then bad wave
        put_tag(32'h0); send_file();
        put_tag(TAG_RIFF); put_tag(0); put_tag(TAG_FMT); send_file();
        // unsupported codec, short fmt, early end, lookup limit
        put_tag(TAG_RIFF); put_tag(0); put_tag(TAG_WAVE);
        put_fmt(16'h0002, 2, 8000, 8, 16); send_file();
        put_tag(TAG_RIFF); put_tag(0); put_tag(TAG_WAVE);
        put_fmt(FMT_PCM, 2, 8000, 8, 12); send_file();
        send_byte(8'h52, 1'b1);
        put_tag(TAG_RIFF); put_tag(0); put_tag(TAG_WAVE);
        put_hdr(32'h5453494C, LOOKUP_LIMIT); send_file();
        write_file_length(32'h0);
        put_tag(TAG_RIFF); put_tag(0); put_tag(TAG_WAVE);
        put_fmt(FMT_PCM, 1, 48000, 16, 18);
        put_hdr(TAG_DATA, 0); send_file();
    endtask

    task automatic test_random(int target);
        int files;
        files = 0;
        while (n_bytes < target) begin
            if (files % 150 == 75)
                write_file_length($urandom);
            if (files == 40)
                hold_off = 1'b1;
            if (files == 90)
                wait_drained();
            no_stall = (files % 60) < 10;
            build_random_file();
            send_file();
            files++;
        end
        no_stall = 1'b0;
    endtask

    // receiver stall pattern plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= no_stall || ($urandom_range(0, 3) != 0);
    end

    initial begin
        wait (hold_off);
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (report_q.size() == 0) begin
                $display("%0t unexpected result status=%0d", $time, got.status);
                errors++;
            end else begin
                fmt_report_t e;
                e = report_q.pop_front();
                if (e.status != got.status) begin $display("%0t status exp %0h got %0h", $time, e.status, got.status); errors++; end
                if (e.header_length != got.header_length) begin $display("%0t header_length exp %0h got %0h", $time, e.header_length, got.header_length); errors++; end
                if (e.data_length != got.data_length) begin $display("%0t data_length exp %0h got %0h", $time, e.data_length, got.data_length); errors++; end
                if (e.num_channels != got.num_channels) begin $display("%0t num_channels exp %0h got %0h", $time, e.num_channels, got.num_channels); errors++; end
                if (e.samples_per_sec != got.samples_per_sec) begin $display("%0t samples_per_sec exp %0h got %0h", $time, e.samples_per_sec, got.samples_per_sec); errors++; end
                if (e.sample_bits != got.sample_bits) begin $display("%0t sample_bits exp %0h got %0h", $time, e.sample_bits, got.sample_bits); errors++; end
                if (e.float_samples != got.float_samples) begin $display("%0t float_samples exp %0h got %0h", $time, e.float_samples, got.float_samples); errors++; end
                if (e.frame_bytes != got.frame_bytes) begin $display("%0t frame_bytes exp %0h got %0h", $time, e.frame_bytes, got.frame_bytes); errors++; end
                if (e.bitrate != got.bitrate) begin $display("%0t bitrate exp %0h got %0h", $time, e.bitrate, got.bitrate); errors++; end
                if (e.duration_ms != got.duration_ms) begin $display("%0t duration_ms exp %0h got %0h", $time, e.duration_ms, got.duration_ms); errors++; end
                if (e.info_flags != got.info_flags) begin $display("%0t info_flags exp %0h got %0h", $time, e.info_flags, got.info_flags); errors++; end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0;
        idle_cycles = 0;
        n_bytes = 0;
        hold_off = 1'b0;
        no_stall = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        file_byte = '0;
        last_byte = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        p_file_length = '0;
        foreach (p_fmt[i]) p_fmt[i] = '0;
        parser_restart();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1350);
        wait_drained();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
